// File: design/mandelbrot_pixel_shade_defines.svh
// Assertion macros used by mandelbrot_pixel_shade.sv to check its own behaviour.
// Each macro is empty when SYNTH is defined.
`ifndef MANDELBROT_PIXEL_SHADE_DEFINES_SVH
`define MANDELBROT_PIXEL_SHADE_DEFINES_SVH

`ifndef SYNTH
`define MPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPS_ASSERT_IMP(label, ante, cons, msg)
`define MPS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: design/mps_pkg.sv
package mps_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SHADE_W    = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_ORIGIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_ORIGIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ITERATION_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADE_GAIN      = 3'd5;

    // Reset values: origin -2.0 - 1.0i, steps 3/1000 and 2/600, gain 255/70.
    localparam logic [31:0] RST_REAL_ORIGIN     = 32'hE000_0000;
    localparam logic [31:0] RST_IMAG_ORIGIN     = 32'hF000_0000;
    localparam logic [30:0] RST_REAL_STEP       = 31'd805306;
    localparam logic [30:0] RST_IMAG_STEP       = 31'd894785;
    localparam int          RST_ITERATION_LIMIT = 200;
    localparam logic [15:0] RST_SHADE_GAIN      = 16'd933;

    localparam logic [SHADE_W-1:0] SHADE_MAX = 8'hFF;

    typedef struct packed {
        logic signed [31:0] real_origin;
        logic signed [31:0] imag_origin;
        logic [30:0]        real_step;
        logic [30:0]        imag_step;
        logic [15:0]        shade_gain;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_status_t;

endpackage

// File: design/mps_mul.sv
// Shared signed multiplier with a registered product.
module mps_mul #(
    parameter int WIDTH = 32
) (
    input  logic                      clk,
    input  logic signed [WIDTH-1:0]   a,
    input  logic signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0] prod
);

    logic signed [2*WIDTH-1:0] prod_reg;
    logic signed [2*WIDTH-1:0] prod_next;

    assign prod_next = a * b;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// File: design/mps_core.sv
// Sequencer and datapath for one pixel; every product goes through mps_mul.
module mps_core #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int FRAC_BITS        = 28,
    parameter int ITER_COUNT_BITS  = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [PIXEL_COORD_BITS-1:0]  col,
    input  logic [PIXEL_COORD_BITS-1:0]  row,
    input  mps_pkg::cfg_t                cfg,
    input  logic [ITER_COUNT_BITS-1:0]   iter_limit,
    input  logic                         take,
    output mps_pkg::core_status_t        status,
    output logic [mps_pkg::SHADE_W-1:0]  shade,
    output logic                         escaped,
    output logic [ITER_COUNT_BITS-1:0]   index
);

    localparam int MW  = (FRAC_BITS + 3 > 32) ? FRAC_BITS + 3 : 32;
    localparam int PW  = 2 * MW;
    localparam int SW  = PW + 1;
    localparam int QW  = FRAC_BITS + 3;
    localparam int CW  = FRAC_BITS + 4;
    localparam int SQW = FRAC_BITS + 4;
    localparam int ZW  = FRAC_BITS + 5;

    localparam logic signed [SW-1:0] C_MAX  = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] C_MIN  = -(SW'(1) << (CW - 1));
    localparam logic signed [ZW-1:0] TWO_P  = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] TWO_N  = -(ZW'(1) << (FRAC_BITS + 1));
    localparam logic signed [ZW-1:0] FOUR   = ZW'(1) << (FRAC_BITS + 2);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CRE_MUL = 4'd1;
    localparam logic [3:0] S_CIM_MUL = 4'd2;
    localparam logic [3:0] S_CIM_ADD = 4'd3;
    localparam logic [3:0] S_RI_MUL  = 4'd4;
    localparam logic [3:0] S_UPD     = 4'd5;
    localparam logic [3:0] S_SQR_RE  = 4'd6;
    localparam logic [3:0] S_SQR_IM  = 4'd7;
    localparam logic [3:0] S_TEST    = 4'd8;
    localparam logic [3:0] S_SHADE   = 4'd9;
    localparam logic [3:0] S_SAT     = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]                  state_reg, state_next;
    logic [PIXEL_COORD_BITS-1:0] col_reg, col_next;
    logic [PIXEL_COORD_BITS-1:0] row_reg, row_next;
    logic signed [CW-1:0]        c_re_reg, c_re_next;
    logic signed [CW-1:0]        c_im_reg, c_im_next;
    logic signed [ZW-1:0]        zre_reg, zre_next;
    logic signed [ZW-1:0]        zim_reg, zim_next;
    logic signed [SQW-1:0]       sq_re_reg, sq_re_next;
    logic signed [SQW-1:0]       sq_im_reg, sq_im_next;
    logic [ITER_COUNT_BITS-1:0]  idx_reg, idx_next;
    logic [mps_pkg::SHADE_W-1:0] shade_reg, shade_next;
    logic                        esc_reg, esc_next;
    logic [ITER_COUNT_BITS-1:0]  index_reg, index_next;

    logic signed [MW-1:0]        mul_a, mul_b;
    logic signed [PW-1:0]        prod;
    logic signed [31:0]          org;
    logic signed [SW-1:0]        coord_sum;
    logic signed [CW-1:0]        coord_sat;
    logic signed [SQW-1:0]       prod_q;
    logic signed [ZW-1:0]        rei2;
    logic signed [ZW-1:0]        new_re, new_im;
    logic signed [QW-1:0]        re_q, im_q;
    logic                        out_of_range;
    logic signed [ZW-1:0]        sq_sum;
    logic                        esc_test;
    logic                        last_iter;
    logic [mps_pkg::SHADE_W-1:0] shade_sat;

    mps_mul #(
        .WIDTH (MW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CRE_MUL:
            begin
                mul_a = MW'(col_reg);
                mul_b = MW'(cfg.real_step);
            end
            S_CIM_MUL:
            begin
                mul_a = MW'(row_reg);
                mul_b = MW'(cfg.imag_step);
            end
            S_RI_MUL:
            begin
                mul_a = MW'(re_q);
                mul_b = MW'(im_q);
            end
            S_SQR_RE:
            begin
                mul_a = MW'(re_q);
                mul_b = MW'(re_q);
            end
            S_SQR_IM:
            begin
                mul_a = MW'(im_q);
                mul_b = MW'(im_q);
            end
            S_SHADE:
            begin
                mul_a = MW'(idx_reg);
                mul_b = MW'(cfg.shade_gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Coordinate: origin plus pixel times step, clamped to the Q format.
    assign org       = (state_reg == S_CIM_MUL) ? cfg.real_origin : cfg.imag_origin;
    assign coord_sum = SW'(org) + SW'(prod);
    assign coord_sat = (coord_sum > C_MAX) ? C_MAX[CW-1:0] :
                       (coord_sum < C_MIN) ? C_MIN[CW-1:0] : coord_sum[CW-1:0];

    // Product scaled back by the fraction width, rounding towards minus infinity.
    assign prod_q = prod[FRAC_BITS +: SQW];
    assign rei2   = {prod_q, 1'b0};
    assign new_re = ZW'(sq_re_reg) - ZW'(sq_im_reg) + ZW'(c_re_reg);
    assign new_im = rei2 + ZW'(c_im_reg);

    // Once both parts are within two their narrow form is exact.
    assign re_q = zre_reg[QW-1:0];
    assign im_q = zim_reg[QW-1:0];
    assign out_of_range = (zre_reg > TWO_P) || (zre_reg < TWO_N) ||
                          (zim_reg > TWO_P) || (zim_reg < TWO_N);

    assign sq_sum    = ZW'(sq_re_reg) + ZW'(prod_q);
    assign esc_test  = sq_sum > FOUR;
    assign last_iter = (idx_reg == iter_limit - ITER_COUNT_BITS'(1));
    assign shade_sat = (prod[PW-1:16] != '0) ? mps_pkg::SHADE_MAX : prod[15:8];

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        zre_next   = zre_reg;
        zim_next   = zim_reg;
        sq_re_next = sq_re_reg;
        sq_im_next = sq_im_reg;
        idx_next   = idx_reg;
        shade_next = shade_reg;
        esc_next   = esc_reg;
        index_next = index_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    col_next   = col;
                    row_next   = row;
                    state_next = S_CRE_MUL;
                end
            end
            S_CRE_MUL:
            begin
                state_next = S_CIM_MUL;
            end
            S_CIM_MUL:
            begin
                c_re_next  = coord_sat;
                state_next = S_CIM_ADD;
            end
            S_CIM_ADD:
            begin
                c_im_next  = coord_sat;
                zre_next   = '0;
                zim_next   = '0;
                sq_re_next = '0;
                sq_im_next = '0;
                idx_next   = '0;
                if (iter_limit == '0)
                begin
                    shade_next = mps_pkg::SHADE_MAX;
                    esc_next   = 1'b0;
                    index_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RI_MUL;
                end
            end
            S_RI_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                zre_next   = new_re;
                zim_next   = new_im;
                state_next = S_SQR_RE;
            end
            S_SQR_RE:
            begin
                if (out_of_range)
                begin
                    state_next = S_SHADE;
                end
                else
                begin
                    state_next = S_SQR_IM;
                end
            end
            S_SQR_IM:
            begin
                sq_re_next = prod_q;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                sq_im_next = prod_q;
                if (esc_test)
                begin
                    state_next = S_SHADE;
                end
                else if (last_iter)
                begin
                    shade_next = mps_pkg::SHADE_MAX;
                    esc_next   = 1'b0;
                    index_next = iter_limit;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + ITER_COUNT_BITS'(1);
                    state_next = S_RI_MUL;
                end
            end
            S_SHADE:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                shade_next = shade_sat;
                esc_next   = 1'b1;
                index_next = idx_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        c_re_reg  <= c_re_next;
        c_im_reg  <= c_im_next;
        zre_reg   <= zre_next;
        zim_reg   <= zim_next;
        sq_re_reg <= sq_re_next;
        sq_im_reg <= sq_im_next;
        idx_reg   <= idx_next;
        shade_reg <= shade_next;
        esc_reg   <= esc_next;
        index_reg <= index_next;
    end

    assign status.busy = (state_reg != S_IDLE);
    assign status.done = (state_reg == S_DONE);
    assign shade       = shade_reg;
    assign escaped     = esc_reg;
    assign index       = index_reg;

endmodule

// File: design/mandelbrot_pixel_shade.sv
// Mandelbrot escape-time shader for one pixel at a time.
// The slave stream carries a pixel item (column, row); the master stream returns one item
// per pixel with its grey level, an escape flag and the escape index. The point
// c = origin + pixel * step is formed in signed fixed point, then z = z*z + c is iterated
// from zero until the magnitude exceeds two or the iteration limit is reached.
// All arithmetic runs through one shared multiplier, registered at its output, under a
// small sequencer. Forming c takes three steps, each iteration five (re*im, update,
// re squared, im squared, test), and shading an escaped point two more. A part of z
// that passes two skips the last two steps of the iteration and goes to shading. The
// next pixel is accepted only once the sequencer is idle again, so the rate is set by
// the iteration count. s_tready is high only while the sequencer is idle. A finished
// result moves into the output register as soon as it is empty, so a new pixel can be
// accepted while the previous result still waits; if the receiver stalls with the
// output full, the sequencer holds its result and accepts nothing further. Reset
// empties the output register, returns the sequencer to idle and loads the default
// view (origin -2.0 - 1.0i, 200 iterations). The user must write configuration only
// while idle; the block itself does not enforce it.
`include "mandelbrot_pixel_shade_defines.svh"

module mandelbrot_pixel_shade #(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int FRAC_BITS        = 28,
    parameter int ITER_COUNT_BITS  = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel items: pixel_col, pixel_row, zero padding.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*PIXEL_COORD_BITS+7)/8)*8-1:0] s_tdata,
    // Result items: shade, escaped, escape_index, zero padding.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((mps_pkg::SHADE_W+1+ITER_COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [mps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int OUT_W = ((mps_pkg::SHADE_W + 1 + ITER_COUNT_BITS + 7) / 8) * 8;

    // Configuration registers.
    mps_pkg::cfg_t               cfg_reg, cfg_next;
    logic [ITER_COUNT_BITS-1:0]  limit_reg, limit_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [mps_pkg::SHADE_W-1:0] out_shade_reg, out_shade_next;
    logic                        out_esc_reg, out_esc_next;
    logic [ITER_COUNT_BITS-1:0]  out_index_reg, out_index_next;

    mps_pkg::core_status_t       core_status;
    logic [mps_pkg::SHADE_W-1:0] core_shade;
    logic                        core_esc;
    logic [ITER_COUNT_BITS-1:0]  core_index;
    logic                        start;
    logic                        take;

    assign s_tready = !core_status.busy;
    assign start    = s_tvalid && s_tready;
    // The core's result is taken whenever the output register is empty or draining.
    assign take     = core_status.done && (!out_valid_reg || m_tready);

    mps_core #(
        .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
        .FRAC_BITS        (FRAC_BITS),
        .ITER_COUNT_BITS  (ITER_COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .col        (s_tdata[PIXEL_COORD_BITS-1:0]),
        .row        (s_tdata[2*PIXEL_COORD_BITS-1:PIXEL_COORD_BITS]),
        .cfg        (cfg_reg),
        .iter_limit (limit_reg),
        .take       (take),
        .status     (core_status),
        .shade      (core_shade),
        .escaped    (core_esc),
        .index      (core_index)
    );

    // Register writes.
    always_comb
    begin
        cfg_next   = cfg_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                mps_pkg::REG_REAL_ORIGIN:     cfg_next.real_origin = cfg_data;
                mps_pkg::REG_IMAG_ORIGIN:     cfg_next.imag_origin = cfg_data;
                mps_pkg::REG_REAL_STEP:       cfg_next.real_step   = cfg_data[30:0];
                mps_pkg::REG_IMAG_STEP:       cfg_next.imag_step   = cfg_data[30:0];
                mps_pkg::REG_ITERATION_LIMIT: limit_next = cfg_data[ITER_COUNT_BITS-1:0];
                mps_pkg::REG_SHADE_GAIN:      cfg_next.shade_gain  = cfg_data[15:0];
                default:
                begin
                    cfg_next   = cfg_reg;
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    // Output register: loads the core's result, empties when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_shade_next = out_shade_reg;
        out_esc_next   = out_esc_reg;
        out_index_next = out_index_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            out_shade_next = core_shade;
            out_esc_next   = core_esc;
            out_index_next = core_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_origin <= mps_pkg::RST_REAL_ORIGIN;
            cfg_reg.imag_origin <= mps_pkg::RST_IMAG_ORIGIN;
            cfg_reg.real_step   <= mps_pkg::RST_REAL_STEP;
            cfg_reg.imag_step   <= mps_pkg::RST_IMAG_STEP;
            cfg_reg.shade_gain  <= mps_pkg::RST_SHADE_GAIN;
            limit_reg           <= ITER_COUNT_BITS'(mps_pkg::RST_ITERATION_LIMIT);
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_shade_reg <= out_shade_next;
        out_esc_reg   <= out_esc_next;
        out_index_reg <= out_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_index_reg, out_esc_reg, out_shade_reg});

    // A result waiting on a full, stalled output register stays with the core.
    `MPS_ASSERT_NXT(a_result_held, core_status.done && out_valid_reg && !m_tready,
        core_status.done, "core result dropped while the output register was stalled")
    // An accepted pixel always starts the sequencer.
    `MPS_ASSERT_NXT(a_start_busy, s_tvalid && s_tready, core_status.busy,
        "accepted pixel did not start the sequencer")
    // An escaped point escapes before the limit is used up.
    `MPS_ASSERT_IMP(a_esc_index, out_valid_reg && out_esc_reg, out_index_reg < limit_reg,
        "escape index not below the iteration limit")
    // A point that never escapes is shaded full white.
    `MPS_ASSERT_IMP(a_inside_shade, out_valid_reg && !out_esc_reg,
        out_shade_reg == mps_pkg::SHADE_MAX, "non-escaping point not at full shade")

endmodule
